@@ src/kgsa_pkg.sv @@
// shared types, constants and helpers of the gradient splat and advect core
`default_nettype none

package kgsa_pkg;

  localparam int MAP_SIDE_DEF   = 256;
  localparam int MAX_KERNEL_DEF = 31;

  localparam int KW          = 6;   // kernel side and tap counters, up to 63
  localparam int MW          = 11;  // used map side, up to 2047
  localparam int PW          = 18;  // point coordinate, signed Q10.8
  localparam int CW          = 20;  // widened coordinate for tap and step math
  localparam int GW          = 32;  // map cell
  localparam int ATW         = 16;  // attraction, unsigned Q8.8
  localparam int DIV_NW      = 48;  // divider numerator and quotient
  localparam int DIV_DW      = 32;  // divider denominator
  localparam int QDEPTH      = 2;   // request queue depth
  localparam int RECIP_SHIFT = 20;  // fraction bits of the kernel reciprocal
  localparam int CONE_NW     = 20;  // cone numerator

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_SPLAT  = 2'd1,
    REQ_ADVECT = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef struct packed {
    req_t                  req;
    logic signed [PW-1:0]  px;
    logic signed [PW-1:0]  py;
    logic                  in_map;
  } item_t;

  typedef struct packed {
    logic [KW-1:0]  k;
    logic [MW-1:0]  m;
    logic [ATW-1:0] att;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // strictly inside (0, m*256)
  function automatic logic in_lim(input logic signed [CW-1:0] p, input logic [MW-1:0] m);
    logic signed [CW-1:0] lim;
    lim = $signed({1'b0, m, 8'h00});
    return (p > 0) && (p < lim);
  endfunction

endpackage

`default_nettype wire

@@ src/kde_gradient_splat_and_advect_core.sv @@
// top level of the gradient density splat and advect core
`default_nettype none

// Gradient density splat and advect core. Two square maps of signed 32-bit Q.8
// cells hold the x and y gradient density; a request is clear, splat or advect
// and every request gives exactly one result, strobed by out_valid for a single
// cycle, which the receiver must take as it comes. A request is taken when start
// is high and busy is low. After reset the maps are swept to zero, one cell of
// both maps per cycle, with busy high. A clear request takes the same sweep. A
// splat first computes the kernel reciprocal on the shared divider, then for
// each kernel tap that lands inside the map reads the cells, computes four cone
// values and writes back; a tap that falls outside is skipped. An advect runs a
// normalizing shift, a square root at one result bit per cycle and two
// divisions. Requests queue two deep behind the intake register, so start may
// be pulsed while the execution side is still working.
module kde_gradient_splat_and_advect_core import kgsa_pkg::*; #(
  parameter int MAP_SIDE   = MAP_SIDE_DEF,
  parameter int MAX_KERNEL = MAX_KERNEL_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // request channel
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           in_req_type,
  input  wire logic signed [PW-1:0] in_point_x,
  input  wire logic signed [PW-1:0] in_point_y,
  // result channel
  output logic                      out_valid,
  output logic signed [PW-1:0]      out_new_x,
  output logic signed [PW-1:0]      out_new_y,
  output logic                      out_moved,
  // configuration write port
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [ATW-1:0]       cfg_data
);

  localparam logic [1:0] REG_KERNEL_SIZE = 2'd0;
  localparam logic [1:0] REG_MAP_SIDE    = 2'd1;
  localparam logic [1:0] REG_ATTRACTION  = 2'd2;

  logic [4:0]     kernel_size_r;
  logic [8:0]     map_side_r;
  logic [ATW-1:0] attraction_r;

  cfg_t    cfg;
  item_t   push_item;
  item_t   pop_item;
  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  logic    init_busy;

  // configuration registers, to be written only while idle; the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_size_r <= 5'd11;
      map_side_r    <= 9'd256;
      attraction_r  <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KERNEL_SIZE: kernel_size_r <= cfg_data[4:0];
        REG_MAP_SIDE:    map_side_r    <= cfg_data[8:0];
        REG_ATTRACTION:  attraction_r  <= cfg_data;
        default: begin
          attraction_r <= attraction_r;
        end
      endcase
    end
  end

  // kernel side clamped to 1..MAX_KERNEL, map side to 2..MAP_SIDE
  always_comb begin
    if (kernel_size_r == '0) begin
      cfg.k = KW'(1);
    end else if (KW'(kernel_size_r) > KW'(MAX_KERNEL)) begin
      cfg.k = KW'(MAX_KERNEL);
    end else begin
      cfg.k = KW'(kernel_size_r);
    end
    if (map_side_r < 9'd2) begin
      cfg.m = MW'(2);
    end else if (MW'(map_side_r) > MW'(MAP_SIDE)) begin
      cfg.m = MW'(MAP_SIDE);
    end else begin
      cfg.m = MW'(map_side_r);
    end
    cfg.att = attraction_r;
  end

  // intake: one request register, tags in-map advect points
  kgsa_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req_type (in_req_type),
    .in_point_x  (in_point_x),
    .in_point_y  (in_point_y),
    .cfg_m       (cfg.m),
    .hold        (init_busy),
    .q_stat      (q_stat),
    .push        (q_push),
    .push_item   (push_item)
  );

  // decouples intake from the long-running execution side
  kgsa_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  // maps, splat sequencer and advect datapath
  kgsa_back #(
    .MAP_SIDE (MAP_SIDE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_item    (pop_item),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .out_valid (out_valid),
    .out_new_x (out_new_x),
    .out_new_y (out_new_y),
    .out_moved (out_moved)
  );

  // no push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_stat.full))
    else $error("request pushed into full queue");

  // no pop from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_stat.empty))
    else $error("request popped from empty queue");

  // no result during the power-up sweep
  a_quiet_init: assert property (@(posedge clk) disable iff (!rst_n)
    init_busy |-> !out_valid)
    else $error("result during initial clear");

  // moved only marks a strobed result
  a_moved_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_moved |-> out_valid)
    else $error("moved without result strobe");

endmodule

`default_nettype wire

@@ src/kgsa_front.sv @@
// request intake: captures a request and tags advect points that lie inside the map
`default_nettype none

module kgsa_front import kgsa_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           in_req_type,
  input  wire logic signed [PW-1:0] in_point_x,
  input  wire logic signed [PW-1:0] in_point_y,
  input  wire logic [MW-1:0]        cfg_m,
  input  wire logic                 hold,
  input  wire q_stat_t              q_stat,
  output logic                      push,
  output item_t                     push_item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  item_t item_nxt;
  logic  accept;

  assign busy   = hold || (valid_r && q_stat.full);
  assign accept = start && !busy;
  assign push   = valid_r && !q_stat.full;
  assign push_item = item_r;

  always_comb begin
    item_nxt.req    = req_t'(in_req_type);
    item_nxt.px     = in_point_x;
    item_nxt.py     = in_point_y;
    item_nxt.in_map = in_lim(CW'(in_point_x), cfg_m) && in_lim(CW'(in_point_y), cfg_m);
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (push) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/kgsa_fifo.sv @@
// short request queue between intake and execution
`default_nettype none

module kgsa_fifo import kgsa_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output item_t      pop_item,
  output q_stat_t    q_stat
);

  localparam int PTW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNW = $clog2(QDEPTH + 1);

  item_t          ent_r [QDEPTH];
  logic [PTW-1:0] wr_ptr_r;
  logic [PTW-1:0] rd_ptr_r;
  logic [CNW-1:0] cnt_r;

  assign q_stat.full  = (cnt_r == CNW'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_item     = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/kgsa_div.sv @@
// restoring divider, one quotient bit per cycle
`default_nettype none

module kgsa_div import kgsa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIV_NW-1:0] num,
  input  wire logic [DIV_DW-1:0] den,
  output logic                   done,
  output logic [DIV_NW-1:0]      quo
);

  localparam int CNTW = $clog2(DIV_NW + 1);

  logic [DIV_NW-1:0] quo_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] den_r;
  logic [CNTW-1:0]   cnt_r;
  logic              run_r;
  logic              done_r;

  logic [DIV_DW:0]   shifted;
  logic [DIV_DW:0]   diff;
  logic              ge;

  assign shifted = {rem_r, quo_r[DIV_NW-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign ge      = (shifted >= {1'b0, den_r});
  assign done    = done_r;
  assign quo     = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && run_r && (cnt_r == CNTW'(1));
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNTW'(DIV_NW);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (run_r) begin
      quo_r <= {quo_r[DIV_NW-2:0], ge};
      rem_r <= ge ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
    end
  end

endmodule

`default_nettype wire

@@ src/kgsa_back.sv @@
// execution side: gradient maps, clear sweep, splat sequencer and advect datapath
`default_nettype none

module kgsa_back import kgsa_pkg::*; #(
  parameter int MAP_SIDE = MAP_SIDE_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cfg_t          cfg,
  input  wire item_t         q_item,
  input  wire q_stat_t       q_stat,
  output logic               q_pop,
  output logic               init_busy,
  output logic               out_valid,
  output logic signed [PW-1:0] out_new_x,
  output logic signed [PW-1:0] out_new_y,
  output logic               out_moved
);

  localparam int DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CXW   = $clog2(MAP_SIDE);

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SP_RGO,
    ST_SP_RWAIT,
    ST_SP_TAP,
    ST_SP_CONE,
    ST_SP_WRITE,
    ST_AD_READ,
    ST_AD_CHK,
    ST_AD_NORM,
    ST_AD_SQ1,
    ST_AD_SQ2,
    ST_AD_SQRT,
    ST_AD_NUM,
    ST_AD_DGO,
    ST_AD_DWAIT,
    ST_AD_OUT,
    ST_DONE
  } state_t;

  function automatic logic signed [GW-1:0] sat_add(input logic signed [GW-1:0] a,
                                                   input logic signed [9:0] g);
    logic signed [GW:0] s;
    s = (GW+1)'(a) + (GW+1)'(g);
    if (s[GW] != s[GW-1]) begin
      return s[GW] ? {1'b1, {(GW-1){1'b0}}} : {1'b0, {(GW-1){1'b1}}};
    end
    return s[GW-1:0];
  endfunction

  function automatic logic signed [PW-1:0] sat18(input logic signed [CW-1:0] v);
    if (v[CW-1:PW-1] == '0 || v[CW-1:PW-1] == '1) begin
      return v[PW-1:0];
    end
    return v[CW-1] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
  endfunction

  logic signed [GW-1:0] mem_x [DEPTH];
  logic signed [GW-1:0] mem_y [DEPTH];

  state_t               state_r;
  logic [AW-1:0]        clr_addr_r;
  item_t                cur_r;
  logic [KW-1:0]        tx_r;
  logic [KW-1:0]        ty_r;
  logic [RECIP_SHIFT:0] recip_r;
  logic [1:0]           cone_sel_r;
  logic [1:0]           cone_ph_r;
  logic [CONE_NW-1:0]   cn_r;
  logic                 cz_r;
  logic [8:0]           cq0_r;
  logic [8:0]           cone_v_r [4];
  logic [AW-1:0]        tap_addr_r;
  logic signed [GW-1:0] rdx_r;
  logic signed [GW-1:0] rdy_r;
  logic [31:0]          ax_r;
  logic [31:0]          ay_r;
  logic                 sgx_r;
  logic                 sgy_r;
  logic [63:0]          sq_r;
  logic [63:0]          v_r;
  logic [63:0]          root_r;
  logic [63:0]          b_r;
  logic [DIV_NW-1:0]    num_r;
  logic                 dsel_r;
  logic [16:0]          stx_r;
  logic [16:0]          sty_r;
  logic signed [PW-1:0] nx_r;
  logic signed [PW-1:0] ny_r;
  logic                 moved_r;
  logic                 out_valid_r;
  logic signed [PW-1:0] out_x_r;
  logic signed [PW-1:0] out_y_r;
  logic                 out_moved_r;

  // kernel geometry
  logic [KW-1:0]        km1;
  logic [2*KW-1:0]      hh;
  logic [KW-1:0]        xa;
  logic [KW-1:0]        xb;
  logic [KW-1:0]        ya;
  logic [KW-1:0]        yb;
  logic [KW-1:0]        ca;
  logic [KW-1:0]        cb;
  logic signed [KW+1:0] cc;
  logic signed [KW+1:0] ee;
  logic signed [15:0]   csq;
  logic signed [15:0]   esq;
  logic [15:0]          dd;
  logic                 cz_nxt;
  logic [CONE_NW-1:0]   cn_nxt;
  logic [CONE_NW+RECIP_SHIFT:0] cprod;
  logic [CONE_NW:0]     crem;
  logic [8:0]           cqv;
  logic signed [9:0]    gx;
  logic signed [9:0]    gy;
  logic                 last_tap;

  // tap placement
  logic signed [CW-1:0] sx;
  logic signed [CW-1:0] sy;
  logic                 tap_in;
  logic [AW-1:0]        tap_addr;
  logic [AW-1:0]        adv_addr;

  // advect helpers
  logic [63:0]          rb;
  logic signed [CW-1:0] nxs;
  logic signed [CW-1:0] nys;

  // memory ports
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic signed [GW-1:0] mem_wx;
  logic signed [GW-1:0] mem_wy;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;

  // divider
  logic                 div_start;
  logic [DIV_NW-1:0]    div_num;
  logic [DIV_DW-1:0]    div_den;
  logic                 div_done;
  logic [DIV_NW-1:0]    div_quo;

  assign km1 = cfg.k - 1'b1;
  assign hh  = (2*KW)'(cfg.k) * (2*KW)'(cfg.k);

  always_comb begin
    if (tx_r == '0) begin
      xa = '0;
      xb = KW'(1);
    end else if (tx_r == km1) begin
      xa = cfg.k - KW'(2);
      xb = km1;
    end else begin
      xa = tx_r - 1'b1;
      xb = tx_r + 1'b1;
    end
    if (ty_r == '0) begin
      ya = '0;
      yb = KW'(1);
    end else if (ty_r == km1) begin
      ya = cfg.k - KW'(2);
      yb = km1;
    end else begin
      ya = ty_r - 1'b1;
      yb = ty_r + 1'b1;
    end
    unique case (cone_sel_r)
      2'd0: begin
        ca = xa;
        cb = ty_r;
      end
      2'd1: begin
        ca = xb;
        cb = ty_r;
      end
      2'd2: begin
        ca = tx_r;
        cb = ya;
      end
      default: begin
        ca = tx_r;
        cb = yb;
      end
    endcase
  end

  // cone value: ((H-D)*256 + H/2) / H via reciprocal and one correction
  assign cc     = $signed({1'b0, ca, 1'b0}) - $signed({2'b00, km1});
  assign ee     = $signed({1'b0, cb, 1'b0}) - $signed({2'b00, km1});
  assign csq    = cc * cc;
  assign esq    = ee * ee;
  assign dd     = 16'(csq + esq);
  assign cz_nxt = (dd >= 16'(hh));
  assign cn_nxt = {hh - dd[2*KW-1:0], 8'h00} + CONE_NW'(hh >> 1);
  assign cprod  = (CONE_NW+RECIP_SHIFT+1)'(cn_r) * (CONE_NW+RECIP_SHIFT+1)'(recip_r);
  assign crem   = {1'b0, cn_r} - (CONE_NW+1)'(cq0_r * hh);
  assign cqv    = cz_r ? 9'd0 : ((crem >= (CONE_NW+1)'(hh)) ? cq0_r + 1'b1 : cq0_r);

  always_comb begin
    if (cfg.k < KW'(2)) begin
      gx = '0;
      gy = '0;
    end else begin
      gx = $signed({1'b0, cone_v_r[0]}) - $signed({1'b0, cone_v_r[1]});
      gy = $signed({1'b0, cone_v_r[2]}) - $signed({1'b0, cone_v_r[3]});
    end
  end

  assign last_tap = (tx_r == km1) && (ty_r == km1);

  assign sx = CW'(cur_r.px) - CW'({cfg.k >> 1, 8'h00}) + CW'({tx_r, 8'h00});
  assign sy = CW'(cur_r.py) - CW'({cfg.k >> 1, 8'h00}) + CW'({ty_r, 8'h00});
  assign tap_in   = in_lim(sx, cfg.m) && in_lim(sy, cfg.m);
  assign tap_addr = AW'(sx[8 +: CXW]) * AW'(MAP_SIDE) + AW'(sy[8 +: CXW]);
  assign adv_addr = AW'(cur_r.px[8 +: CXW]) * AW'(MAP_SIDE) + AW'(cur_r.py[8 +: CXW]);

  assign rb  = root_r + b_r;
  assign nxs = sgx_r ? CW'(cur_r.px) + CW'(stx_r) : CW'(cur_r.px) - CW'(stx_r);
  assign nys = sgy_r ? CW'(cur_r.py) + CW'(sty_r) : CW'(cur_r.py) - CW'(sty_r);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr_r;
    mem_wx    = '0;
    mem_wy    = '0;
    mem_re    = 1'b0;
    mem_raddr = adv_addr;
    unique case (state_r)
      ST_INIT, ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_SP_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = tap_addr_r;
        mem_wx    = sat_add(rdx_r, gx);
        mem_wy    = sat_add(rdy_r, gy);
      end
      ST_SP_TAP: begin
        mem_re    = 1'b1;
        mem_raddr = tap_addr;
      end
      ST_AD_READ: begin
        mem_re = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_x[mem_waddr] <= mem_wx;
      mem_y[mem_waddr] <= mem_wy;
    end
    if (mem_re) begin
      rdx_r <= mem_x[mem_raddr];
      rdy_r <= mem_y[mem_raddr];
    end
  end

  assign div_start = (state_r == ST_SP_RGO) || (state_r == ST_AD_DGO);
  assign div_num   = (state_r == ST_SP_RGO) ? DIV_NW'(1) << RECIP_SHIFT : num_r;
  assign div_den   = (state_r == ST_SP_RGO) ? DIV_DW'(hh) : root_r[DIV_DW-1:0];

  kgsa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign q_pop     = (state_r == ST_IDLE) && !q_stat.empty;
  assign init_busy = (state_r == ST_INIT);
  assign out_valid = out_valid_r;
  assign out_new_x = out_x_r;
  assign out_new_y = out_y_r;
  assign out_moved = out_moved_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      out_moved_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_DONE);
      out_moved_r <= (state_r == ST_DONE) && moved_r;
      unique case (state_r)
        ST_INIT: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == AW'(DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!q_stat.empty) begin
            cur_r   <= q_item;
            nx_r    <= q_item.px;
            ny_r    <= q_item.py;
            moved_r <= 1'b0;
            tx_r    <= '0;
            ty_r    <= '0;
            unique case (q_item.req)
              REQ_CLEAR: begin
                clr_addr_r <= '0;
                state_r    <= ST_CLEAR;
              end
              REQ_SPLAT: begin
                state_r <= ST_SP_RGO;
              end
              REQ_ADVECT: begin
                state_r <= q_item.in_map ? ST_AD_READ : ST_DONE;
              end
              default: begin
                state_r <= ST_DONE;
              end
            endcase
          end
        end
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == AW'(DEPTH - 1)) begin
            state_r <= ST_DONE;
          end
        end
        ST_SP_RGO: begin
          state_r <= ST_SP_RWAIT;
        end
        ST_SP_RWAIT: begin
          if (div_done) begin
            recip_r <= div_quo[RECIP_SHIFT:0];
            state_r <= ST_SP_TAP;
          end
        end
        ST_SP_TAP: begin
          if (tap_in) begin
            tap_addr_r <= tap_addr;
            cone_sel_r <= '0;
            cone_ph_r  <= '0;
            state_r    <= ST_SP_CONE;
          end else if (last_tap) begin
            state_r <= ST_DONE;
          end else if (tx_r == km1) begin
            tx_r <= '0;
            ty_r <= ty_r + 1'b1;
          end else begin
            tx_r <= tx_r + 1'b1;
          end
        end
        ST_SP_CONE: begin
          unique case (cone_ph_r)
            2'd0: begin
              cn_r      <= cn_nxt;
              cz_r      <= cz_nxt;
              cone_ph_r <= 2'd1;
            end
            2'd1: begin
              cq0_r     <= cprod[RECIP_SHIFT +: 9];
              cone_ph_r <= 2'd2;
            end
            default: begin
              cone_v_r[cone_sel_r] <= cqv;
              cone_ph_r <= 2'd0;
              if (cone_sel_r == 2'd3) begin
                state_r <= ST_SP_WRITE;
              end else begin
                cone_sel_r <= cone_sel_r + 1'b1;
              end
            end
          endcase
        end
        ST_SP_WRITE: begin
          if (last_tap) begin
            state_r <= ST_DONE;
          end else begin
            state_r <= ST_SP_TAP;
            if (tx_r == km1) begin
              tx_r <= '0;
              ty_r <= ty_r + 1'b1;
            end else begin
              tx_r <= tx_r + 1'b1;
            end
          end
        end
        ST_AD_READ: begin
          state_r <= ST_AD_CHK;
        end
        ST_AD_CHK: begin
          if (rdx_r == '0 && rdy_r == '0) begin
            state_r <= ST_DONE;
          end else begin
            ax_r    <= rdx_r[GW-1] ? 32'(-rdx_r) : 32'(rdx_r);
            ay_r    <= rdy_r[GW-1] ? 32'(-rdy_r) : 32'(rdy_r);
            sgx_r   <= rdx_r[GW-1];
            sgy_r   <= rdy_r[GW-1];
            state_r <= ST_AD_NORM;
          end
        end
        ST_AD_NORM: begin
          // shift both until the larger magnitude reaches 2^30
          if (ax_r[31:30] == 2'b00 && ay_r[31:30] == 2'b00) begin
            ax_r <= {ax_r[30:0], 1'b0};
            ay_r <= {ay_r[30:0], 1'b0};
          end else begin
            state_r <= ST_AD_SQ1;
          end
        end
        ST_AD_SQ1: begin
          sq_r    <= 64'(ax_r) * 64'(ay_r - ay_r + ax_r);
          state_r <= ST_AD_SQ2;
        end
        ST_AD_SQ2: begin
          v_r     <= sq_r + 64'(ay_r) * 64'(ay_r);
          root_r  <= '0;
          b_r     <= 64'(1) << 62;
          state_r <= ST_AD_SQRT;
        end
        ST_AD_SQRT: begin
          if (v_r >= rb) begin
            v_r    <= v_r - rb;
            root_r <= (root_r >> 1) + b_r;
          end else begin
            root_r <= root_r >> 1;
          end
          b_r <= b_r >> 2;
          if (b_r == 64'(1)) begin
            dsel_r  <= 1'b0;
            state_r <= ST_AD_NUM;
          end
        end
        ST_AD_NUM: begin
          num_r <= DIV_NW'((dsel_r ? 48'(ay_r) : 48'(ax_r)) * 48'(cfg.att))
                   + DIV_NW'(root_r >> 1);
          state_r <= ST_AD_DGO;
        end
        ST_AD_DGO: begin
          state_r <= ST_AD_DWAIT;
        end
        ST_AD_DWAIT: begin
          if (div_done) begin
            if (dsel_r) begin
              sty_r   <= div_quo[16:0];
              state_r <= ST_AD_OUT;
            end else begin
              stx_r   <= div_quo[16:0];
              dsel_r  <= 1'b1;
              state_r <= ST_AD_NUM;
            end
          end
        end
        ST_AD_OUT: begin
          nx_r    <= sat18(nxs);
          ny_r    <= sat18(nys);
          moved_r <= 1'b1;
          state_r <= ST_DONE;
        end
        default: begin
          out_x_r <= nx_r;
          out_y_r <= ny_r;
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ tb/kgsa_checker.sv @@
// request and result checker with its own predictor of the splat and advect core
`timescale 1ns / 1ps

module kgsa_checker import kgsa_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 busy,
  input  wire logic [1:0]           in_req_type,
  input  wire logic signed [PW-1:0] in_point_x,
  input  wire logic signed [PW-1:0] in_point_y,
  input  wire logic                 out_valid,
  input  wire logic signed [PW-1:0] out_new_x,
  input  wire logic signed [PW-1:0] out_new_y,
  input  wire logic                 out_moved,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [ATW-1:0]       cfg_data,
  output int                        n_fail,
  output int                        n_pending
);

  localparam int SIDE = MAP_SIDE_DEF;
  localparam logic [1:0] IDX_KERNEL = 2'd0;
  localparam logic [1:0] IDX_SIDE   = 2'd1;
  localparam logic [1:0] IDX_ATTR   = 2'd2;

  typedef struct {
    logic signed [PW-1:0] nx;
    logic signed [PW-1:0] ny;
    logic                 moved;
  } point_res_t;

  int         grad_x_map [SIDE*SIDE];
  int         grad_y_map [SIDE*SIDE];
  logic [4:0] kern_reg;
  logic [8:0] side_reg;
  logic [15:0] attr_reg;
  point_res_t moved_points [$];

  function automatic longint kern_used();
    return (kern_reg < 1) ? 1 : ((kern_reg > MAX_KERNEL_DEF) ? MAX_KERNEL_DEF : kern_reg);
  endfunction

  function automatic longint side_used();
    return (side_reg < 2) ? 2 : ((side_reg > SIDE) ? SIDE : side_reg);
  endfunction

  function automatic longint cone_val(longint x, longint y, longint k);
    longint c, e, d, h;
    c = 2*x - (k-1);
    e = 2*y - (k-1);
    d = c*c + e*e;
    h = k*k;
    if (d >= h) return 0;
    return ((h-d)*256 + h/2) / h;
  endfunction

  // one-sided differences at the kernel edges
  function automatic longint slope_x(longint x, longint y, longint k);
    if (k < 2) return 0;
    if (x == 0) return cone_val(0, y, k) - cone_val(1, y, k);
    if (x == k-1) return cone_val(k-2, y, k) - cone_val(k-1, y, k);
    return cone_val(x-1, y, k) - cone_val(x+1, y, k);
  endfunction

  function automatic longint slope_y(longint x, longint y, longint k);
    if (k < 2) return 0;
    if (y == 0) return cone_val(x, 0, k) - cone_val(x, 1, k);
    if (y == k-1) return cone_val(x, k-2, k) - cone_val(x, k-1, k);
    return cone_val(x, y-1, k) - cone_val(x, y+1, k);
  endfunction

  function automatic int cell_add(int a, longint b);
    longint s;
    s = longint'(a) + b;
    if (s > 64'sd2147483647) return 32'sh7fffffff;
    if (s < -64'sd2147483648) return 32'sh80000000;
    return int'(s);
  endfunction

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint clip18(longint v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  task automatic splat_kernel(longint px, longint py);
    longint k, lim, bx, by, sx, sy;
    int idx;
    k = kern_used();
    lim = side_used() * 256;
    bx = px - (k/2)*256;
    by = py - (k/2)*256;
    for (longint y = 0; y < k; y++) begin
      for (longint x = 0; x < k; x++) begin
        sx = bx + x*256;
        sy = by + y*256;
        if (sx > 0 && sy > 0 && sx < lim && sy < lim) begin
          idx = int'((sx >>> 8) * SIDE + (sy >>> 8));
          grad_x_map[idx] = cell_add(grad_x_map[idx], slope_x(x, y, k));
          grad_y_map[idx] = cell_add(grad_y_map[idx], slope_y(x, y, k));
        end
      end
    end
  endtask

  function automatic point_res_t predict_point(logic [1:0] req, longint px, longint py);
    point_res_t res;
    longint lim, gx, gy;
    logic [63:0] ax, ay, l, sx, sy;
    int idx;
    res.nx = px[PW-1:0];
    res.ny = py[PW-1:0];
    res.moved = 1'b0;
    if (req == REQ_ADVECT) begin
      lim = side_used() * 256;
      if (px > 0 && py > 0 && px < lim && py < lim) begin
        idx = int'((px >>> 8) * SIDE + (py >>> 8));
        gx = grad_x_map[idx];
        gy = grad_y_map[idx];
        if (gx != 0 || gy != 0) begin
          ax = (gx < 0) ? -gx : gx;
          ay = (gy < 0) ? -gy : gy;
          while (((ax > ay) ? ax : ay) < (64'd1 << 30)) begin
            ax = ax << 1;
            ay = ay << 1;
          end
          l  = root64(ax*ax + ay*ay);
          sx = (ax * attr_reg + l/2) / l;
          sy = (ay * attr_reg + l/2) / l;
          res.nx = PW'(clip18((gx < 0) ? px + longint'(sx) : px - longint'(sx)));
          res.ny = PW'(clip18((gy < 0) ? py + longint'(sy) : py - longint'(sy)));
          res.moved = 1'b1;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    point_res_t want;
    if (!rst_n) begin
      foreach (grad_x_map[i]) begin
        grad_x_map[i] = 0;
        grad_y_map[i] = 0;
      end
      kern_reg = 5'd11;
      side_reg = 9'd256;
      attr_reg = 16'd256;
      moved_points.delete();
      n_fail = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          IDX_KERNEL: kern_reg = cfg_data[4:0];
          IDX_SIDE:   side_reg = cfg_data[8:0];
          IDX_ATTR:   attr_reg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid) begin
        if (moved_points.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("unexpected result x=%0d y=%0d moved=%0b",
                     out_new_x, out_new_y, out_moved);
        end else begin
          want = moved_points.pop_front();
          if (want.nx !== out_new_x || want.ny !== out_new_y || want.moved !== out_moved) begin
            n_fail++;
            if (n_fail <= 10)
              $display("mismatch: expected x=%0d y=%0d moved=%0b, got x=%0d y=%0d moved=%0b",
                       want.nx, want.ny, want.moved, out_new_x, out_new_y, out_moved);
          end
        end
      end
      // a request accepted now is predicted after any result leaving this edge
      if (start && !busy) begin
        moved_points.push_back(predict_point(in_req_type, in_point_x, in_point_y));
        if (in_req_type == REQ_CLEAR) begin
          foreach (grad_x_map[i]) begin
            grad_x_map[i] = 0;
            grad_y_map[i] = 0;
          end
        end else if (in_req_type == REQ_SPLAT) begin
          splat_kernel(in_point_x, in_point_y);
        end
      end
    end
    n_pending = moved_points.size();
  end

endmodule

@@ tb/tb_top.sv @@
// stimulus, clock and verdict for the splat and advect core regression
`timescale 1ns / 1ps

module tb_top;
  import kgsa_pkg::*;

  localparam logic [1:0] IDX_KERNEL = 2'd0;
  localparam logic [1:0] IDX_SIDE   = 2'd1;
  localparam logic [1:0] IDX_ATTR   = 2'd2;
  localparam int CYCLE_LIMIT = 6000000;
  localparam int PHASE_REQS  = 190;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           in_req_type = REQ_NONE;
  logic signed [PW-1:0] in_point_x = '0;
  logic signed [PW-1:0] in_point_y = '0;
  logic                 out_valid;
  logic signed [PW-1:0] out_new_x;
  logic signed [PW-1:0] out_new_y;
  logic                 out_moved;
  logic                 cfg_we = 1'b0;
  logic [1:0]           cfg_index = '0;
  logic [ATW-1:0]       cfg_data = '0;
  int                   n_fail;
  int                   n_pending;
  int                   cycles = 0;

  // current settings, mirrored for stimulus shaping only
  int cur_k = 11;
  int cur_lim = 256*256;
  int idle_pct = 0;
  int hot_x [4];
  int hot_y [4];

  kde_gradient_splat_and_advect_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_point_x(in_point_x), .in_point_y(in_point_y),
    .out_valid(out_valid), .out_new_x(out_new_x), .out_new_y(out_new_y),
    .out_moved(out_moved),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  kgsa_checker u_check (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_point_x(in_point_x), .in_point_y(in_point_y),
    .out_valid(out_valid), .out_new_x(out_new_x), .out_new_y(out_new_y),
    .out_moved(out_moved),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .n_fail(n_fail), .n_pending(n_pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog: clear sweeps dominate the run time, the limit leaves ample room
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("kde_gradient_splat_and_advect_core regression: fail");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after the request is taken, or later after random idling
  task automatic send_request(logic [1:0] req, int x, int y);
    start       <= 1'b1;
    in_req_type <= req;
    in_point_x  <= x[PW-1:0];
    in_point_y  <= y[PW-1:0];
    while (busy) @(negedge clk);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      in_req_type <= 2'($urandom);
      @(negedge clk);
    end
  endtask

  // hold off until every expected result is in, then let the core settle
  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (n_pending != 0 || busy) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  // settings change only with the core idle
  task automatic write_settings(int k, int m, int att);
    int mu;
    wait_drained();
    cfg_we <= 1'b1; cfg_index <= IDX_KERNEL; cfg_data <= ATW'(k);
    @(negedge clk);
    cfg_index <= IDX_SIDE; cfg_data <= ATW'(m);
    @(negedge clk);
    cfg_index <= IDX_ATTR; cfg_data <= ATW'(att);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    cur_k = (k < 1) ? 1 : ((k > MAX_KERNEL_DEF) ? MAX_KERNEL_DEF : k);
    mu = (m < 2) ? 2 : ((m > MAP_SIDE_DEF) ? MAP_SIDE_DEF : m);
    cur_lim = mu * 256;
    foreach (hot_x[i]) begin
      hot_x[i] = $urandom_range(1, cur_lim - 1);
      hot_y[i] = $urandom_range(1, cur_lim - 1);
    end
  endtask

  // edge values of a coordinate around the used map bounds and the field range
  function automatic int edge_coord();
    case ($urandom_range(0, 6))
      0: return 0;
      1: return 1;
      2: return cur_lim - 1;
      3: return cur_lim;
      4: return -1;
      5: return 131071;
      default: return -131072;
    endcase
  endfunction

  task automatic random_phase(int n, int splat_pct);
    int r, h, x, y, span;
    logic [1:0] req;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      req = (r < splat_pct) ? REQ_SPLAT : ((r < 97) ? REQ_ADVECT : REQ_NONE);
      r = $urandom_range(0, 99);
      h = $urandom_range(0, 3);
      span = cur_k * 256;
      if (r < 10) begin
        // noise over the whole field range
        x = $signed(18'($urandom));
        y = $signed(18'($urandom));
      end else if (r < 17) begin
        x = edge_coord();
        y = (r < 14) ? hot_y[h] : edge_coord();
      end else begin
        // cluster around a hot spot so advects find gradient
        x = hot_x[h] + $urandom_range(0, 2*span) - span;
        y = hot_y[h] + $urandom_range(0, 2*span) - span;
      end
      send_request(req, x, y);
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    write_settings(11, 256, 256);

    // directed part at reset settings
    send_request(REQ_ADVECT, 1000, 1000);          // zero gradient
    send_request(REQ_SPLAT, 1000, 1000);
    wait_drained();                                // sender pause until all results are in
    send_request(REQ_ADVECT, 1000, 1000);          // cell under the point
    send_request(REQ_ADVECT, 1300, 800);
    send_request(REQ_ADVECT, 700, 1200);
    send_request(REQ_SPLAT, 100, 65500);           // kernel clipped at map edges
    send_request(REQ_ADVECT, 100, 65500);
    send_request(REQ_ADVECT, 0, 500);              // on the lower bound
    send_request(REQ_ADVECT, 500, 65536);          // on the upper bound
    send_request(REQ_ADVECT, -131072, -131072);
    send_request(REQ_ADVECT, 131071, 131071);
    send_request(REQ_SPLAT, -131072, 131071);      // fully outside
    send_request(REQ_NONE, 131071, -131072);       // unused request
    send_request(REQ_NONE, -1, 0);
    send_request(REQ_CLEAR, 5, -5);
    send_request(REQ_ADVECT, 1000, 1000);          // gradient gone after clear
    write_settings(1, 256, 65535);
    send_request(REQ_SPLAT, 2000, 2000);           // single-cell kernel adds nothing
    send_request(REQ_ADVECT, 2000, 2000);
    write_settings(3, 256, 65535);
    send_request(REQ_SPLAT, 65000, 65000);
    send_request(REQ_ADVECT, 65300, 65000);        // cell just outside the kernel, no step
    send_request(REQ_ADVECT, 64800, 64800);

    // random part over several settings and idling modes
    write_settings(3, 256, 256);      idle_pct = 0;  random_phase(PHASE_REQS, 40);
    write_settings(5, 32, 65535);     idle_pct = 82; random_phase(PHASE_REQS, 40);
    write_settings(0, 0, 1);          idle_pct = 13;
    send_request(REQ_CLEAR, 300, 300);
    random_phase(PHASE_REQS, 40);
    write_settings(31, 511, 128);     idle_pct = 0;  random_phase(PHASE_REQS, 3);
    write_settings(7, 16, 65535);     idle_pct = 82; random_phase(PHASE_REQS, 30);
    write_settings(2, 200, 0);        idle_pct = 13;
    send_request(REQ_CLEAR, -300, 300);
    random_phase(PHASE_REQS, 40);
    write_settings(11, 256, 256);     idle_pct = 0;  random_phase(PHASE_REQS, 8);

    wait_drained();
    if (n_fail + n_pending == 0) begin
      $display("kde_gradient_splat_and_advect_core regression: pass");
    end else begin
      $display("kde_gradient_splat_and_advect_core regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/kgsa_pkg.sv
src/kgsa_front.sv
src/kgsa_fifo.sv
src/kgsa_div.sv
src/kgsa_back.sv
src/kde_gradient_splat_and_advect_core.sv
tb/kgsa_checker.sv
tb/tb_top.sv
